/* design/spq_pkg.sv */
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

  // field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 5;

  // default number of held entries
  localparam int unsigned DefaultQueueDepth = 16;

  // command codes
  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  // status codes
  typedef enum logic [StatusW-1:0] {
    StatusDone  = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  // one stored entry
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] priority_key;
  } entry_t;

endpackage

/* design/sorted_priority_queue_unit.sv */
// sorted priority queue held in a circular single-port-read, single-port-write memory
//
//  channel   direction  signals                                          handshake
//  command   in         cmd_i, item_value_i, item_priority_i            start_i && !busy_o
//  result    out        status_o, out_value_o, out_priority_o,           result_valid_o, one cycle
//                       fill_level_o
//
// refused push or pop, and push into an empty queue: result in the cycle after acceptance
// pop: result from StPopRd, once the head entry is read (one memory read)
// push: result after StShift moves up each greater-keyed entry and StWrNew if the new
//   entry lands at the head; the walk from the tail reads one entry and writes one per cycle
// reset clears the sequencer, count and head; the memory is never cleared
// the receiver cannot stall: each result word is shown for exactly one cycle
module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefaultQueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cmd_i,
  input  logic signed [spq_pkg::DataW-1:0]    item_value_i,
  input  logic signed [spq_pkg::DataW-1:0]    item_priority_i,
  output logic                                result_valid_o,
  output logic [spq_pkg::StatusW-1:0]         status_o,
  output logic signed [spq_pkg::DataW-1:0]    out_value_o,
  output logic signed [spq_pkg::DataW-1:0]    out_priority_o,
  output logic [spq_pkg::FillW-1:0]           fill_level_o
);

  localparam int unsigned AW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MemDepth = 1 << AW;

  // sequencer codes
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPopRd = 2'd1;
  localparam logic [1:0] StShift = 2'd2;
  localparam logic [1:0] StWrNew = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  spq_pkg::entry_t new_q, new_d;

  // memory and its ports
  spq_pkg::entry_t mem_q [MemDepth];
  spq_pkg::entry_t rd_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  spq_pkg::entry_t mem_wdata;

  // result word
  logic                             res_valid_q, res_valid_d;
  logic [spq_pkg::StatusW-1:0]      res_status_q, res_status_d;
  logic signed [spq_pkg::DataW-1:0] res_val_q, res_val_d;
  logic signed [spq_pkg::DataW-1:0] res_pri_q, res_pri_d;
  logic [spq_pkg::FillW-1:0]        res_fill_q;

  logic full, empty, accept, greater;

  assign full    = (count_q == CW'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign accept  = start_i && (state_q == StIdle);
  assign greater = (rd_q.priority_key > new_q.priority_key);

  // sequencer: pop reads the head; push reads, compares and moves entries from the tail down
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    new_d        = new_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = head_q;
    mem_raddr    = head_q;
    mem_wdata    = new_q;
    res_valid_d  = 1'b0;
    res_status_d = spq_pkg::StatusDone;
    res_val_d    = '0;
    res_pri_d    = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i == spq_pkg::CmdPop) begin
            if (empty) begin
              res_valid_d  = 1'b1;
              res_status_d = spq_pkg::StatusEmpty;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_q;
              state_d   = StPopRd;
            end
          end else begin
            new_d.value        = item_value_i;
            new_d.priority_key = item_priority_i;
            if (full) begin
              res_valid_d  = 1'b1;
              res_status_d = spq_pkg::StatusFull;
            end else if (empty) begin
              mem_we                 = 1'b1;
              mem_waddr              = head_q;
              mem_wdata.value        = item_value_i;
              mem_wdata.priority_key = item_priority_i;
              count_d                = count_q + CW'(1);
              res_valid_d            = 1'b1;
            end else begin
              idx_d     = AW'(count_q - CW'(1));
              mem_re    = 1'b1;
              mem_raddr = AW'(head_q + AW'(count_q - CW'(1)));
              state_d   = StShift;
            end
          end
        end
      end
      StPopRd: begin
        res_valid_d = 1'b1;
        res_val_d   = rd_q.value;
        res_pri_d   = rd_q.priority_key;
        head_d      = AW'(head_q + AW'(1));
        count_d     = count_q - CW'(1);
        state_d     = StIdle;
      end
      StShift: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(head_q + idx_q + AW'(1));
        if (greater) begin
          // stored entry moves up one place
          mem_wdata = rd_q;
          if (idx_q == '0) begin
            state_d = StWrNew;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(head_q + idx_q - AW'(1));
            idx_d     = AW'(idx_q - AW'(1));
          end
        end else begin
          // new entry lands right after this one
          mem_wdata   = new_q;
          count_d     = count_q + CW'(1);
          res_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StWrNew: begin
        mem_we      = 1'b1;
        mem_waddr   = head_q;
        mem_wdata   = new_q;
        count_d     = count_q + CW'(1);
        res_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_val_q    <= res_val_d;
      res_pri_q    <= res_pri_d;
      res_fill_q   <= spq_pkg::FillW'(count_d);
    end
  end

  // entry memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign out_value_o    = res_val_q;
  assign out_priority_o = res_pri_q;
  assign fill_level_o   = res_fill_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> result_valid_o || busy_o)
    else $error("accepted command neither answered nor in progress");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == spq_pkg::StatusEmpty |-> fill_level_o == '0)
    else $error("empty pop reports a non-zero fill level");

  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("memory read and write at the same entry");

endmodule
